// ----- design/rrt_pkg.sv -----
package rrt_pkg;

   // Table size default
   localparam int SLOTS_DEFAULT = 64;

   // Register port shape
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RESEND_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT   = 1'b1;

   // Register reset values
   localparam logic [15:0] RESEND_PERIOD_RESET = 16'd500;
   localparam logic [3:0]  RETRY_LIMIT_RESET   = 4'd5;

   // Request codes
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_ACK     = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   // Event codes
   localparam logic [2:0] EV_ENQUEUED      = 3'd0;
   localparam logic [2:0] EV_TABLE_FULL    = 3'd1;
   localparam logic [2:0] EV_ACK_MATCHED   = 3'd2;
   localparam logic [2:0] EV_ACK_UNMATCHED = 3'd3;
   localparam logic [2:0] EV_RESEND        = 3'd4;
   localparam logic [2:0] EV_GIVE_UP       = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] msg_id;
      logic [15:0] dest_id;
      logic [15:0] elapsed;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [5:0]  slot;
      logic [31:0] event_id;
      logic [15:0] event_target;
      logic        last;
   } rsp_payload_type;

   // Which result goes to the output register this cycle
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_HIT,
      EMIT_MISS,
      EMIT_PEND_MID,
      EMIT_PEND_LAST
   } emit_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         accept;
      logic         advance;
      logic         commit;
      logic         load_pend;
      emit_sel_type emit;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       chk_valid;
      logic       hit;
      logic       scan_done;
      logic       pend_valid;
      logic       out_space;
   } dp_status_type;

endpackage

// ----- design/rrt_datapath.sv -----
module rrt_datapath #(
   parameter int SLOTS = rrt_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  rrt_pkg::req_payload_type         req_data,
   input  rrt_pkg::ctl_cmd_type             cmd,
   output rrt_pkg::dp_status_type           status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rrt_pkg::rsp_payload_type         rsp_data
);
   import rrt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] target;
      logic [15:0] timer;
      logic [3:0]  retries;
   } entry_type;

   // Configuration
   logic [15:0] cfg_interval_ff;
   logic [3:0]  cfg_max_ff;

   // Latched request
   logic [1:0]  op_ff;
   logic [31:0] id_ff;
   logic [15:0] tgt_ff;
   logic [15:0] el_ff;

   // Slot table
   logic [SLOTS-1:0] valid_ff;
   entry_type        mem [SLOTS];
   entry_type        rdata_ff;

   // Scan pipeline
   logic [CNT_W-1:0] rd_idx_ff;
   logic             chk_valid_ff;
   logic [IDX_W-1:0] chk_idx_ff;
   logic             rd_done;
   logic             mem_re;

   // Pending tick event
   logic            pend_valid_ff;
   rsp_payload_type pend_ff;

   // Output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // Check stage
   logic            cur_valid;
   logic            id_match;
   logic [16:0]     t_sum;
   logic [15:0]     t_sat;
   logic            trigger;
   logic            give_up;
   logic            hit;
   logic            mem_we;
   entry_type       wr_entry;
   rsp_payload_type tick_event;
   rsp_payload_type emit_data;
   logic [5:0]      slot_out;

   assign rd_done   = (rd_idx_ff == CNT_W'(SLOTS));
   assign mem_re    = cmd.advance && !rd_done;
   assign cur_valid = valid_ff[chk_idx_ff];
   assign id_match  = (rdata_ff.id == id_ff);
   assign t_sum     = {1'b0, rdata_ff.timer} + {1'b0, el_ff};
   assign t_sat     = t_sum[16] ? 16'hFFFF : t_sum[15:0];
   assign trigger   = (t_sat >= cfg_interval_ff);
   assign give_up   = (rdata_ff.retries >= cfg_max_ff);
   assign slot_out  = 6'(chk_idx_ff);

   // Hit test per request
   always_comb begin
      unique case (op_ff)
         REQ_ENQUEUE: hit = !cur_valid;
         REQ_ACK:     hit = cur_valid && id_match;
         REQ_TICK:    hit = cur_valid && trigger;
         default:     hit = 1'b0;
      endcase
   end

   // Table write-back
   always_comb begin
      wr_entry = rdata_ff;
      mem_we   = 1'b0;
      if (cmd.commit && (op_ff == REQ_ENQUEUE)) begin
         mem_we           = 1'b1;
         wr_entry.id      = id_ff;
         wr_entry.target  = tgt_ff;
         wr_entry.timer   = '0;
         wr_entry.retries = '0;
      end else if (cmd.commit && (op_ff == REQ_TICK) && cur_valid) begin
         mem_we         = 1'b1;
         wr_entry.timer = trigger ? 16'd0 : t_sat;
         if (trigger && !give_up) begin
            wr_entry.retries = 4'(rdata_ff.retries + 4'd1);
         end
      end
   end

   // Tick event for the slot under check
   always_comb begin
      tick_event.event_kind   = give_up ? EV_GIVE_UP : EV_RESEND;
      tick_event.slot         = slot_out;
      tick_event.event_id     = rdata_ff.id;
      tick_event.event_target = rdata_ff.target;
      tick_event.last         = 1'b0;
   end

   // Result selection
   always_comb begin
      emit_data = pend_ff;
      unique case (cmd.emit)
         EMIT_HIT: begin
            emit_data.slot = slot_out;
            emit_data.last = 1'b1;
            if (op_ff == REQ_ENQUEUE) begin
               emit_data.event_kind   = EV_ENQUEUED;
               emit_data.event_id     = id_ff;
               emit_data.event_target = tgt_ff;
            end else begin
               emit_data.event_kind   = EV_ACK_MATCHED;
               emit_data.event_id     = rdata_ff.id;
               emit_data.event_target = rdata_ff.target;
            end
         end
         EMIT_MISS: begin
            emit_data.slot     = '0;
            emit_data.event_id = id_ff;
            emit_data.last     = 1'b1;
            if (op_ff == REQ_ENQUEUE) begin
               emit_data.event_kind   = EV_TABLE_FULL;
               emit_data.event_target = tgt_ff;
            end else begin
               emit_data.event_kind   = EV_ACK_UNMATCHED;
               emit_data.event_target = '0;
            end
         end
         EMIT_PEND_MID:  emit_data.last = 1'b0;
         EMIT_PEND_LAST: emit_data.last = 1'b1;
         default:        emit_data = pend_ff;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_interval_ff <= RESEND_PERIOD_RESET;
         cfg_max_ff      <= RETRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RESEND_PERIOD: cfg_interval_ff <= csr_wdata;
            CSR_RETRY_LIMIT:   cfg_max_ff      <= csr_wdata[3:0];
            default:           cfg_max_ff      <= cfg_max_ff;
         endcase
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_data.req_type;
         id_ff  <= req_data.msg_id;
         tgt_ff <= req_data.dest_id;
         el_ff  <= req_data.elapsed;
      end
   end

   // Slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[chk_idx_ff] <= wr_entry;
      end
      if (mem_re) begin
         rdata_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         if (op_ff == REQ_ENQUEUE) begin
            valid_ff[chk_idx_ff] <= 1'b1;
         end else if (op_ff == REQ_ACK) begin
            valid_ff[chk_idx_ff] <= 1'b0;
         end else if ((op_ff == REQ_TICK) && cur_valid && trigger && give_up) begin
            valid_ff[chk_idx_ff] <= 1'b0;
         end
      end
   end

   // Scan pipeline: read stage then check stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         chk_valid_ff <= 1'b0;
         chk_idx_ff   <= '0;
      end else if (cmd.accept) begin
         rd_idx_ff    <= '0;
         chk_valid_ff <= 1'b0;
      end else if (cmd.advance) begin
         if (!rd_done) begin
            chk_idx_ff   <= rd_idx_ff[IDX_W-1:0];
            chk_valid_ff <= 1'b1;
            rd_idx_ff    <= rd_idx_ff + CNT_W'(1);
         end else begin
            chk_valid_ff <= 1'b0;
         end
      end
   end

   // Pending tick event, held until the next one shows whether it is final
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.load_pend) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.emit == EMIT_PEND_LAST) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pend) begin
         pend_ff <= tick_event;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to controller
   assign status.op         = op_ff;
   assign status.chk_valid  = chk_valid_ff;
   assign status.hit        = hit;
   assign status.scan_done  = !chk_valid_ff && rd_done;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_space  = !rsp_valid_ff || rsp_ready;

endmodule

// ----- design/rrt_ctrl.sv -----
module rrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_kind,
   output logic                    req_ready,
   input  rrt_pkg::dp_status_type  status,
   output rrt_pkg::ctl_cmd_type    cmd
);
   import rrt_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;
   logic      req_ready_in;
   logic      take;
   logic      done;

   assign take = req_valid && req_ready_ff;

   // Command decode
   always_comb begin
      cmd.accept    = 1'b0;
      cmd.advance   = 1'b0;
      cmd.commit    = 1'b0;
      cmd.load_pend = 1'b0;
      cmd.emit      = EMIT_NONE;
      done          = 1'b0;
      if (state_ff == ST_IDLE) begin
         cmd.accept = take && (req_kind != REQ_UNUSED);
      end else begin
         priority if (status.chk_valid && status.hit) begin
            unique case (status.op)
               REQ_ENQUEUE, REQ_ACK: begin
                  if (status.out_space) begin
                     cmd.commit = 1'b1;
                     cmd.emit   = EMIT_HIT;
                     done       = 1'b1;
                  end
               end
               REQ_TICK: begin
                  // a new event pushes the held one out
                  if (!status.pend_valid || status.out_space) begin
                     cmd.commit    = 1'b1;
                     cmd.load_pend = 1'b1;
                     cmd.advance   = 1'b1;
                     cmd.emit      = status.pend_valid ? EMIT_PEND_MID : EMIT_NONE;
                  end
               end
               default: done = 1'b1;
            endcase
         end else if (status.chk_valid) begin
            cmd.commit  = (status.op == REQ_TICK);
            cmd.advance = 1'b1;
         end else if (status.scan_done) begin
            unique case (status.op)
               REQ_ENQUEUE, REQ_ACK: begin
                  if (status.out_space) begin
                     cmd.emit = EMIT_MISS;
                     done     = 1'b1;
                  end
               end
               REQ_TICK: begin
                  if (!status.pend_valid) begin
                     done = 1'b1;
                  end else if (status.out_space) begin
                     cmd.emit = EMIT_PEND_LAST;
                     done     = 1'b1;
                  end
               end
               default: done = 1'b1;
            endcase
         end else begin
            cmd.advance = 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && (req_kind != REQ_UNUSED)) begin
               state_in     = ST_SCAN;
               req_ready_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (done) begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// ----- design/reliable_retransmit_tracker_unit.sv -----
// One item at a time. Enqueue scans to the first free slot, and an ack to the slot whose ID matches;
// the scan stops at that slot and the result is registered.
// Tick, table full and unmatched ack scan the whole table. The one-read-port slot memory is
// visited one slot per cycle, stalling on a slot whose event finds the result register full.
// Reset: valid bits clear, resend period 500, retry limit 5; no clearing pass.
module reliable_retransmit_tracker_unit #(
   parameter int SLOTS = rrt_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rrt_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rrt_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_wr_en,
   input  logic [rrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rrt_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequencer
   rrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Slot table, scan pipeline and result register
   rrt_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/reliable_retransmit_tracker_unit_tb.sv -----
`timescale 1ns / 1ps

module reliable_retransmit_tracker_unit_tb;
   import rrt_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam int SETTLE_CYCLES = SLOTS + 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_payload_type       rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the slot table and registers
   logic        tbl_valid   [SLOTS];
   logic [31:0] tbl_id      [SLOTS];
   logic [15:0] tbl_target  [SLOTS];
   logic [15:0] tbl_timer   [SLOTS];
   logic [3:0]  tbl_retries [SLOTS];
   logic [15:0] interval_shadow;
   logic [3:0]  limit_shadow;

   rsp_payload_type awaited_events [$];
   int fail_count = 0;
   bit sender_idling = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int rsp_hold_cycles = 0;

   reliable_retransmit_tracker_unit #(.SLOTS(SLOTS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_payload_type make_event(input logic [2:0] kind, input int slot_num,
                                                  input logic [31:0] id, input logic [15:0] tgt);
      rsp_payload_type ev;
      ev.event_kind   = kind;
      ev.slot         = 6'(slot_num);
      ev.event_id     = id;
      ev.event_target = tgt;
      ev.last         = 1'b0;
      return ev;
   endfunction

   // Apply one accepted request to the shadow table and queue the events it causes
   task automatic update_slot_table(input req_payload_type item);
      rsp_payload_type found [$];
      logic [16:0] sum;
      int hit;
      hit = -1;
      case (item.req_type)
         REQ_ENQUEUE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!tbl_valid[i]) begin
                  hit = i;
                  break;
               end
            end
            if (hit >= 0) begin
               tbl_valid[hit]   = 1'b1;
               tbl_id[hit]      = item.msg_id;
               tbl_target[hit]  = item.dest_id;
               tbl_timer[hit]   = '0;
               tbl_retries[hit] = '0;
               found.push_back(make_event(EV_ENQUEUED, hit, item.msg_id, item.dest_id));
            end else begin
               found.push_back(make_event(EV_TABLE_FULL, 0, item.msg_id, item.dest_id));
            end
         end
         REQ_ACK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_valid[i] && tbl_id[i] == item.msg_id) begin
                  hit = i;
                  break;
               end
            end
            if (hit >= 0) begin
               tbl_valid[hit] = 1'b0;
               found.push_back(make_event(EV_ACK_MATCHED, hit, tbl_id[hit], tbl_target[hit]));
            end else begin
               found.push_back(make_event(EV_ACK_UNMATCHED, 0, item.msg_id, 16'd0));
            end
         end
         REQ_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_valid[i]) begin
                  // saturating timer, then restart on expiry
                  sum = {1'b0, tbl_timer[i]} + {1'b0, item.elapsed};
                  tbl_timer[i] = sum[16] ? 16'hFFFF : sum[15:0];
                  if (tbl_timer[i] >= interval_shadow) begin
                     tbl_timer[i] = '0;
                     if (tbl_retries[i] >= limit_shadow) begin
                        tbl_valid[i] = 1'b0;
                        found.push_back(make_event(EV_GIVE_UP, i, tbl_id[i], tbl_target[i]));
                     end else begin
                        tbl_retries[i] = tbl_retries[i] + 4'd1;
                        found.push_back(make_event(EV_RESEND, i, tbl_id[i], tbl_target[i]));
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) awaited_events.push_back(found[i]);
   endtask

   // Offer one request and hold it until the transfer
   task automatic send_request(input logic [1:0] kind, input logic [31:0] id,
                               input logic [15:0] tgt, input logic [15:0] elapsed);
      req_payload_type item;
      item.req_type = kind;
      item.msg_id   = id;
      item.dest_id  = tgt;
      item.elapsed  = elapsed;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      update_slot_table(item);
   endtask

   task automatic sender_gap();
      int span;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         span = $urandom_range(1, 19);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (span - 1) @(negedge clock);
      end
   endtask

   // Stop offering, wait for every awaited event, then let a silent scan finish
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_RESEND_PERIOD) interval_shadow = value;
      else limit_shadow = value[3:0];
   endtask

   // Random request biased toward live IDs and ticks near the interval
   task automatic send_random_request();
      int roll;
      int live [$];
      logic [1:0]  kind;
      logic [31:0] id;
      logic [15:0] tgt;
      logic [15:0] elapsed;
      id      = $urandom();
      tgt     = 16'($urandom());
      elapsed = 16'($urandom());
      roll    = $urandom_range(0, 99);
      if (roll < 40) begin
         kind = REQ_ENQUEUE;
         if ($urandom_range(0, 4) == 0) id = $urandom_range(0, 7);
      end else if (roll < 70) begin
         kind = REQ_ACK;
         for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) live.push_back(i);
         if (live.size() > 0 && $urandom_range(0, 4) != 0)
            id = tbl_id[live[$urandom_range(0, live.size() - 1)]];
      end else if (roll < 95) begin
         kind = REQ_TICK;
         case ($urandom_range(0, 3))
            0: elapsed = 16'($urandom_range(0, interval_shadow));
            1: elapsed = interval_shadow;
            2: elapsed = 16'hFFFF;
            default: ;
         endcase
      end else begin
         kind = REQ_UNUSED;
      end
      send_request(kind, id, tgt, elapsed);
   endtask

   // Result side: random stalls, plus a long hold-off on request
   initial begin : rsp_ready_driver
      int span;
      forever begin
         @(negedge clock);
         span = 0;
         if (rsp_hold_cycles > 0) begin
            span = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            span = $urandom_range(1, 19);
         end
         if (span > 0) begin
            rsp_ready <= 1'b0;
            repeat (span) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest awaited event
   always @(posedge clock) begin : event_checker
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_events.size() == 0) begin
            $error("unexpected event: kind %0d slot %0d id %h",
                   rsp_data.event_kind, rsp_data.slot, rsp_data.event_id);
            fail_count++;
         end else begin
            want = awaited_events.pop_front();
            if (rsp_data.event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d, actual %0d", want.event_kind,
                      rsp_data.event_kind);
               fail_count++;
            end
            if (rsp_data.slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_data.slot);
               fail_count++;
            end
            if (rsp_data.event_id !== want.event_id) begin
               $error("event_id: expected %h, actual %h", want.event_id, rsp_data.event_id);
               fail_count++;
            end
            if (rsp_data.event_target !== want.event_target) begin
               $error("event_target: expected %h, actual %h", want.event_target,
                      rsp_data.event_target);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // Default registers: enqueue, duplicates, acks, quiet and firing ticks
   task automatic test_basic_requests();
      send_request(REQ_ENQUEUE, 32'd0, 16'd0, 16'd0);
      send_request(REQ_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(REQ_ENQUEUE, 32'd0, 16'h1234, 16'd0);
      send_request(REQ_ACK, 32'd0, 16'd0, 16'd0);
      send_request(REQ_ACK, 32'h5A5A_A5A5, 16'h7777, 16'd0);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'd0);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'd499);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'd1);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'hFFFF);
      send_request(REQ_ACK, 32'd0, 16'd0, 16'd0);
      send_request(REQ_ENQUEUE, 32'h8000_0001, 16'h8001, 16'd0);
      send_request(REQ_ACK, 32'hFFFF_FFFF, 16'd0, 16'd0);
      wait_until_drained();
   endtask

   // Longest interval, saturating timers, retry limits of 2 and 15
   task automatic test_retry_limit();
      write_register(CSR_RESEND_PERIOD, 16'hFFFF);
      write_register(CSR_RETRY_LIMIT, 16'hFFF2);
      repeat (4) send_request(REQ_TICK, 32'd0, 16'd0, 16'hFFFF);
      wait_until_drained();
      write_register(CSR_RETRY_LIMIT, 16'h000F);
      send_request(REQ_ENQUEUE, 32'h0BAD_F00D, 16'h00FF, 16'd0);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'h8000);
      repeat (17) send_request(REQ_TICK, 32'd0, 16'd0, 16'hFFFF);
      wait_until_drained();
   endtask

   // Fill the table, overflow it, then stall the result side under a full tick
   task automatic test_full_table_backpressure();
      write_register(CSR_RESEND_PERIOD, 16'd1000);
      write_register(CSR_RETRY_LIMIT, 16'd14);
      for (int i = 0; i < SLOTS; i++) begin
         send_request(REQ_ENQUEUE, $urandom(), 16'($urandom()), 16'($urandom()));
         sender_gap();
      end
      send_request(REQ_ENQUEUE, $urandom(), 16'($urandom()), 16'd0);
      send_request(REQ_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'd0);
      rsp_hold_cycles = 400;
      send_request(REQ_TICK, 32'd0, 16'd0, 16'd1000);
      send_request(REQ_ACK, tbl_id[SLOTS-1], 16'd0, 16'd0);
      send_request(REQ_ACK, tbl_id[3], 16'd0, 16'd0);
      send_request(REQ_ENQUEUE, $urandom(), 16'($urandom()), 16'd0);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'd999);
      send_request(REQ_ACK, tbl_id[10], 16'd0, 16'd0);
      wait_until_drained();
      // zero interval: every live slot fires, and no retries left means all give up
      write_register(CSR_RESEND_PERIOD, 16'd0);
      write_register(CSR_RETRY_LIMIT, 16'hABC0);
      send_request(REQ_TICK, 32'd0, 16'd0, 16'd0);
      wait_until_drained();
   endtask

   // Mixed traffic over several register settings; the last phase runs without idling
   task automatic test_random_traffic();
      logic [15:0] interval_pick [5];
      logic [15:0] retries_pick  [5];
      interval_pick = '{16'd1, 16'hFFFF, 16'($urandom_range(20, 2000)),
                        16'($urandom_range(1, 300)), 16'($urandom_range(50, 500))};
      retries_pick  = '{16'd0, 16'd15, 16'($urandom_range(0, 14)),
                        16'($urandom_range(1, 4)), 16'($urandom())};
      for (int phase = 0; phase < 5; phase++) begin
         write_register(CSR_RESEND_PERIOD, interval_pick[phase]);
         write_register(CSR_RETRY_LIMIT, retries_pick[phase]);
         if (phase == 4) begin
            sender_idling = 1'b0;
            rsp_stalls_on = 1'b0;
         end
         repeat (4) begin
            send_random_request();
            sender_gap();
         end
         wait_until_drained();
      end
   endtask

   initial begin
      interval_shadow = RESEND_PERIOD_RESET;
      limit_shadow    = RETRY_LIMIT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i]   = 1'b0;
         tbl_id[i]      = '0;
         tbl_target[i]  = '0;
         tbl_timer[i]   = '0;
         tbl_retries[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_requests();
      test_retry_limit();
      test_full_table_backpressure();
      test_random_traffic();

      wait_until_drained();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- reliable_retransmit_tracker_unit.f -----
design/rrt_pkg.sv
design/rrt_datapath.sv
design/rrt_ctrl.sv
design/reliable_retransmit_tracker_unit.sv
verif/reliable_retransmit_tracker_unit_tb.sv
